// ----- rtl/irfp_pkg.sv -----
package irfp_pkg;

    // fixed field widths
    localparam int HANDLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int ENC_W      = 4;
    localparam int PIXEL_W    = 16;
    localparam int BOUNDS_W   = 64;
    localparam int MODE_W     = 10;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // filter_mode bit positions
    localparam int FM_CREATED_MIN  = 0;
    localparam int FM_CREATED_MAX  = 1;
    localparam int FM_MODIFIED_MIN = 2;
    localparam int FM_MODIFIED_MAX = 3;
    localparam int FM_ENC_CHECK    = 4;
    localparam int FM_FIXED_RATIO  = 5;
    localparam int FM_ENC_LSB      = 6;

    // register reset values
    localparam logic [TIME_W-1:0]   RST_CREATED_MIN  = '0;
    localparam logic [TIME_W-1:0]   RST_CREATED_MAX  = '1;
    localparam logic [TIME_W-1:0]   RST_MODIFIED_MIN = '0;
    localparam logic [TIME_W-1:0]   RST_MODIFIED_MAX = '1;
    localparam logic [BOUNDS_W-1:0] RST_PIXEL_BOUNDS = 64'hFFFF_FFFF_0000_0000;
    localparam logic [MODE_W-1:0]   RST_FILTER_MODE  = '0;
    localparam logic [COUNT_W-1:0]  RST_MAX_RETURNED = '1;
    localparam logic [COUNT_W-1:0]  RST_START_OFFSET = '0;

    localparam logic [COUNT_W-1:0]  COUNT_SAT = '1;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CREATED_MIN  = 3'd0,
        REG_CREATED_MAX  = 3'd1,
        REG_MODIFIED_MIN = 3'd2,
        REG_MODIFIED_MAX = 3'd3,
        REG_PIXEL_BOUNDS = 3'd4,
        REG_FILTER_MODE  = 3'd5,
        REG_MAX_RETURNED = 3'd6,
        REG_START_OFFSET = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        RK_HANDLE  = 1'b0,
        RK_SUMMARY = 1'b1
    } t_result_kind;

    typedef struct packed {
        logic [HANDLE_W-1:0] image_handle;
        logic [TIME_W-1:0]   created_time;
        logic [TIME_W-1:0]   modified_time;
        logic [ENC_W-1:0]    encoding_code;
        logic [PIXEL_W-1:0]  pixel_width;
        logic [PIXEL_W-1:0]  pixel_height;
        logic                list_end;
    } t_record;

    typedef struct packed {
        t_result_kind        result_kind;
        logic [HANDLE_W-1:0] returned_handle;
        logic [COUNT_W-1:0]  returned_count;
        logic                run_last;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0]   created_min;
        logic [TIME_W-1:0]   created_max;
        logic [TIME_W-1:0]   modified_min;
        logic [TIME_W-1:0]   modified_max;
        logic [BOUNDS_W-1:0] pixel_bounds;
        logic [MODE_W-1:0]   filter_mode;
        logic [COUNT_W-1:0]  max_returned;
        logic [COUNT_W-1:0]  start_offset;
    } t_cfg;

    // counter reload on register writes
    typedef struct packed {
        logic               max_we;
        logic               offset_we;
        logic [COUNT_W-1:0] value;
    } t_cnt_load;

    // filter verdict handed to the pager
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                pass;
        logic                last;
    } t_eval;

endpackage

// ----- rtl/irfp_ifs.sv -----
interface irfp_rec_if;
    logic              valid;
    logic              ready;
    irfp_pkg::t_record data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irfp_res_if;
    logic              valid;
    logic              ready;
    irfp_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/irfp_cfg.sv -----
module irfp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [irfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irfp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output irfp_pkg::t_cfg                      o_cfg,
    output irfp_pkg::t_cnt_load                 o_load
);

    irfp_pkg::t_cfg r_cfg;
    irfp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        o_load = '0;
        o_load.value = i_cfg_wdata[irfp_pkg::COUNT_W-1:0];
        if (i_cfg_we) begin
            unique case (irfp_pkg::t_cfg_idx'(i_cfg_idx))
                irfp_pkg::REG_CREATED_MIN: begin
                    n_cfg.created_min = i_cfg_wdata[irfp_pkg::TIME_W-1:0];
                end
                irfp_pkg::REG_CREATED_MAX: begin
                    n_cfg.created_max = i_cfg_wdata[irfp_pkg::TIME_W-1:0];
                end
                irfp_pkg::REG_MODIFIED_MIN: begin
                    n_cfg.modified_min = i_cfg_wdata[irfp_pkg::TIME_W-1:0];
                end
                irfp_pkg::REG_MODIFIED_MAX: begin
                    n_cfg.modified_max = i_cfg_wdata[irfp_pkg::TIME_W-1:0];
                end
                irfp_pkg::REG_PIXEL_BOUNDS: begin
                    n_cfg.pixel_bounds = i_cfg_wdata[irfp_pkg::BOUNDS_W-1:0];
                end
                irfp_pkg::REG_FILTER_MODE: begin
                    n_cfg.filter_mode = i_cfg_wdata[irfp_pkg::MODE_W-1:0];
                end
                irfp_pkg::REG_MAX_RETURNED: begin
                    n_cfg.max_returned = i_cfg_wdata[irfp_pkg::COUNT_W-1:0];
                    o_load.max_we = 1'b1;
                end
                irfp_pkg::REG_START_OFFSET: begin
                    n_cfg.start_offset = i_cfg_wdata[irfp_pkg::COUNT_W-1:0];
                    o_load.offset_we = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.created_min  <= irfp_pkg::RST_CREATED_MIN;
            r_cfg.created_max  <= irfp_pkg::RST_CREATED_MAX;
            r_cfg.modified_min <= irfp_pkg::RST_MODIFIED_MIN;
            r_cfg.modified_max <= irfp_pkg::RST_MODIFIED_MAX;
            r_cfg.pixel_bounds <= irfp_pkg::RST_PIXEL_BOUNDS;
            r_cfg.filter_mode  <= irfp_pkg::RST_FILTER_MODE;
            r_cfg.max_returned <= irfp_pkg::RST_MAX_RETURNED;
            r_cfg.start_offset <= irfp_pkg::RST_START_OFFSET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/irfp_filter.sv -----
module irfp_filter #(
    parameter int TIME_BITS  = 32,
    parameter int PIXEL_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    irfp_rec_if.sink        i_rec,
    input  irfp_pkg::t_cfg  i_cfg,
    input  logic            i_take,
    output logic            o_valid,
    output irfp_pkg::t_eval o_eval
);

    // compare widths after masking to the parameter widths
    localparam int TC  = (TIME_BITS < irfp_pkg::TIME_W) ? TIME_BITS : irfp_pkg::TIME_W;
    localparam int PW  = (PIXEL_BITS < irfp_pkg::PIXEL_W) ? PIXEL_BITS : irfp_pkg::PIXEL_W;
    localparam int EXT = (4 * PIXEL_BITS > irfp_pkg::BOUNDS_W) ? 4 * PIXEL_BITS
                                                               : irfp_pkg::BOUNDS_W;

    logic              r_valid;
    irfp_pkg::t_record r_rec;

    logic [TC-1:0]           ct;
    logic [TC-1:0]           mt;
    logic [EXT-1:0]          bounds_ext;
    logic [PIXEL_BITS-1:0]   min_w;
    logic [PIXEL_BITS-1:0]   min_h;
    logic [PIXEL_BITS-1:0]   max_w;
    logic [PIXEL_BITS-1:0]   max_h;
    logic [PIXEL_BITS-1:0]   w;
    logic [PIXEL_BITS-1:0]   h;
    logic [2*PIXEL_BITS-1:0] prod_hw;
    logic [2*PIXEL_BITS-1:0] prod_wh;
    logic [irfp_pkg::MODE_W-1:0] fm;
    logic                    fail_time;
    logic                    fail_enc;
    logic                    fail_size;
    logic                    fail_ratio;

    assign i_rec.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rec.ready) begin
            r_valid <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec.valid && i_rec.ready) begin
            r_rec <= i_rec.data;
        end
    end

    assign fm = i_cfg.filter_mode;
    assign ct = r_rec.created_time[TC-1:0];
    assign mt = r_rec.modified_time[TC-1:0];

    // bounds above bit 63 read as zero
    assign bounds_ext = EXT'(i_cfg.pixel_bounds);
    assign min_w = bounds_ext[0 +: PIXEL_BITS];
    assign min_h = bounds_ext[PIXEL_BITS +: PIXEL_BITS];
    assign max_w = bounds_ext[2*PIXEL_BITS +: PIXEL_BITS];
    assign max_h = bounds_ext[3*PIXEL_BITS +: PIXEL_BITS];

    assign w = PIXEL_BITS'(r_rec.pixel_width[PW-1:0]);
    assign h = PIXEL_BITS'(r_rec.pixel_height[PW-1:0]);

    // full-precision cross products for the aspect check
    assign prod_hw = (2*PIXEL_BITS)'(max_h) * (2*PIXEL_BITS)'(w);
    assign prod_wh = (2*PIXEL_BITS)'(max_w) * (2*PIXEL_BITS)'(h);

    always_comb begin
        fail_time = (fm[irfp_pkg::FM_CREATED_MIN]  && (ct < i_cfg.created_min[TC-1:0]))
                 || (fm[irfp_pkg::FM_CREATED_MAX]  && (ct > i_cfg.created_max[TC-1:0]))
                 || (fm[irfp_pkg::FM_MODIFIED_MIN] && (mt < i_cfg.modified_min[TC-1:0]))
                 || (fm[irfp_pkg::FM_MODIFIED_MAX] && (mt > i_cfg.modified_max[TC-1:0]));
        fail_enc  = fm[irfp_pkg::FM_ENC_CHECK]
                 && (r_rec.encoding_code != fm[irfp_pkg::FM_ENC_LSB +: irfp_pkg::ENC_W]);
        fail_size = (min_w > w) || (min_h > h) || (max_w < w) || (max_h < h);
        fail_ratio = fm[irfp_pkg::FM_FIXED_RATIO] && (prod_hw != prod_wh);
    end

    assign o_valid       = r_valid;
    assign o_eval.handle = r_rec.image_handle;
    assign o_eval.last   = r_rec.list_end;
    assign o_eval.pass   = !(fail_time || fail_enc || fail_size || fail_ratio);

endmodule

// ----- rtl/irfp_pager.sv -----
module irfp_pager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  irfp_pkg::t_eval     i_eval,
    output logic                o_take,
    input  irfp_pkg::t_cfg      i_cfg,
    input  irfp_pkg::t_cnt_load i_load,
    irfp_res_if.source          o_res
);

    logic [irfp_pkg::COUNT_W-1:0]  r_skip_left;
    logic [irfp_pkg::COUNT_W-1:0]  r_return_left;
    logic [irfp_pkg::COUNT_W-1:0]  r_total;
    logic [irfp_pkg::COUNT_W-1:0]  n_skip_left;
    logic [irfp_pkg::COUNT_W-1:0]  n_return_left;
    logic [irfp_pkg::COUNT_W-1:0]  n_total;

    irfp_pkg::t_result             r_queue [irfp_pkg::RQ_DEPTH];
    logic [irfp_pkg::RQ_PTR_W-1:0] r_wr_ptr;
    logic [irfp_pkg::RQ_PTR_W-1:0] r_rd_ptr;
    logic [irfp_pkg::RQ_CNT_W-1:0] r_count;
    logic [irfp_pkg::RQ_PTR_W-1:0] n_wr_ptr;
    logic [irfp_pkg::RQ_PTR_W-1:0] n_rd_ptr;
    logic [irfp_pkg::RQ_CNT_W-1:0] n_count;

    logic                          hit;
    logic                          emit;
    logic                          push_sum;
    logic                          pop;
    logic [irfp_pkg::RQ_PTR_W-1:0] sum_idx;
    logic [irfp_pkg::COUNT_W-1:0]  total_inc;
    irfp_pkg::t_result             ent_handle;
    irfp_pkg::t_result             ent_sum;

    // room for two entries, since a last record can push a handle and a summary
    assign o_take = i_valid
                 && (r_count <= irfp_pkg::RQ_CNT_W'(irfp_pkg::RQ_DEPTH - 2));

    assign hit      = o_take && i_eval.pass && (r_return_left != '0);
    assign emit     = hit && (r_skip_left == '0);
    assign push_sum = o_take && i_eval.last;
    assign pop      = o_res.valid && o_res.ready;

    assign total_inc = (emit && (r_total != irfp_pkg::COUNT_SAT)) ? r_total + 1'b1
                                                                  : r_total;

    always_comb begin
        n_skip_left   = r_skip_left;
        n_return_left = r_return_left;
        n_total       = total_inc;
        if (hit && !emit) begin
            n_skip_left = r_skip_left - 1'b1;
        end
        if (emit) begin
            n_return_left = r_return_left - 1'b1;
        end
        // reload for the next listing
        if (push_sum) begin
            n_skip_left   = i_cfg.start_offset;
            n_return_left = i_cfg.max_returned;
            n_total       = '0;
        end
        if (i_load.offset_we) begin
            n_skip_left = i_load.value;
        end
        if (i_load.max_we) begin
            n_return_left = i_load.value;
        end
    end

    always_comb begin
        ent_handle.result_kind     = irfp_pkg::RK_HANDLE;
        ent_handle.returned_handle = i_eval.handle;
        ent_handle.returned_count  = '0;
        ent_handle.run_last        = !i_eval.last;
        ent_sum.result_kind        = irfp_pkg::RK_SUMMARY;
        ent_sum.returned_handle    = '0;
        ent_sum.returned_count     = total_inc;
        ent_sum.run_last           = 1'b1;
    end

    assign sum_idx  = r_wr_ptr + irfp_pkg::RQ_PTR_W'(emit);
    assign n_wr_ptr = r_wr_ptr + irfp_pkg::RQ_PTR_W'(emit) + irfp_pkg::RQ_PTR_W'(push_sum);
    assign n_rd_ptr = r_rd_ptr + irfp_pkg::RQ_PTR_W'(pop);
    assign n_count  = r_count + irfp_pkg::RQ_CNT_W'(emit) + irfp_pkg::RQ_CNT_W'(push_sum)
                    - irfp_pkg::RQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left   <= irfp_pkg::RST_START_OFFSET;
            r_return_left <= irfp_pkg::RST_MAX_RETURNED;
            r_total       <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            r_skip_left   <= n_skip_left;
            r_return_left <= n_return_left;
            r_total       <= n_total;
            r_wr_ptr      <= n_wr_ptr;
            r_rd_ptr      <= n_rd_ptr;
            r_count       <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_queue[r_wr_ptr] <= ent_handle;
        end
        if (push_sum) begin
            r_queue[sum_idx] <= ent_sum;
        end
    end

    assign o_res.valid = (r_count != '0);
    assign o_res.data  = r_queue[r_rd_ptr];

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= irfp_pkg::RQ_CNT_W'(irfp_pkg::RQ_DEPTH))
        else $error("result queue overfilled");

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_sum && !i_load.offset_we && !i_load.max_we)
        |=> (r_total == '0) && (r_skip_left == $past(i_cfg.start_offset))
            && (r_return_left == $past(i_cfg.max_returned)))
        else $error("counters not reloaded after end of list");

    a_no_return_when_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (r_return_left == '0) && !i_eval.last
            && !i_load.offset_we && !i_load.max_we)
        |=> $stable(r_total) && $stable(r_skip_left) && $stable(r_wr_ptr))
        else $error("record returned after limit reached");

endmodule

// ----- rtl/image_record_filter_paginator.sv -----
// channel   dir  handshake            payload
// i_rec     in   valid/ready          t_record: handle, times, encoding, size, list_end
// o_res     out  valid/ready          t_result: kind, handle, count, run_last
// cfg       in   i_cfg_we (no ready)  i_cfg_idx selects register, i_cfg_wdata 64 bits
//
// one record per cycle while the queue has room; a record's results enter the queue
// when taken (input register at the transfer, compare and counter update at the take)
// a record can create two results (handle and summary); the 4-entry result queue drains
// one per cycle while o_res.ready is high; input stalls only if under two slots are free
// synchronous active-low reset loads register defaults and empties the pipeline
// an output stall fills the queue, then holds the input register, then drops i_rec.ready
module image_record_filter_paginator #(
    parameter int TIME_BITS  = 32,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    irfp_rec_if.sink                        i_rec,
    irfp_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [irfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [irfp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // register file and counter reload strobes
    irfp_pkg::t_cfg      cfg;
    irfp_pkg::t_cnt_load cnt_load;

    // filter verdict of the registered record
    logic                eval_valid;
    irfp_pkg::t_eval     eval;
    logic                eval_take;

    irfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_load      (cnt_load)
    );

    // input register plus time, encoding, size and aspect compares
    irfp_filter #(
        .TIME_BITS  (TIME_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (i_rec),
        .i_cfg   (cfg),
        .i_take  (eval_take),
        .o_valid (eval_valid),
        .o_eval  (eval)
    );

    // skip/return counters and the result queue feeding o_res
    irfp_pager u_pager (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (eval_valid),
        .i_eval  (eval),
        .o_take  (eval_take),
        .i_cfg   (cfg),
        .i_load  (cnt_load),
        .o_res   (o_res)
    );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

    // run limits
    localparam int          TOTAL_ITEMS   = 1650;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          MAX_REPORTS   = 10;
    localparam int unsigned CYCLE_LIMIT   = 800_000;
    localparam int          RX_HOLD_LEN   = 300;

    // register write masks, one bit per register index
    localparam logic [7:0] ALL_REGS     = 8'hFF;
    localparam logic [7:0] MAX_RET_REG  = 8'd1 << irfp_pkg::REG_MAX_RETURNED;
    localparam logic [7:0] OFFSET_REG   = 8'd1 << irfp_pkg::REG_START_OFFSET;
    localparam logic [7:0] COUNTER_REGS = MAX_RET_REG | OFFSET_REG;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [irfp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [irfp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    irfp_rec_if rec_if ();
    irfp_res_if res_if ();

    image_record_filter_paginator #(
        .TIME_BITS  (irfp_pkg::TIME_W),
        .PIXEL_BITS (irfp_pkg::PIXEL_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the block: registers and paging counters
    irfp_pkg::t_cfg               regs;
    logic [irfp_pkg::COUNT_W-1:0] skip_cnt;
    logic [irfp_pkg::COUNT_W-1:0] return_cnt;
    logic [irfp_pkg::COUNT_W-1:0] returned_total;

    // handle entries and summaries still to come out, oldest first
    irfp_pkg::t_result listing_entries[$];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    // records accepted by the block
    int          sent_records   = 0;

    // idle spans per transfer, and a long receiver hold-off on request
    int tx_idle_max = 10;
    int rx_idle_max = 10;
    int rx_hold     = 0;
    int rx_wait     = 0;

    function automatic irfp_pkg::t_cfg open_config();
        irfp_pkg::t_cfg c;
        c.created_min  = irfp_pkg::RST_CREATED_MIN;
        c.created_max  = irfp_pkg::RST_CREATED_MAX;
        c.modified_min = irfp_pkg::RST_MODIFIED_MIN;
        c.modified_max = irfp_pkg::RST_MODIFIED_MAX;
        c.pixel_bounds = irfp_pkg::RST_PIXEL_BOUNDS;
        c.filter_mode  = irfp_pkg::RST_FILTER_MODE;
        c.max_returned = irfp_pkg::RST_MAX_RETURNED;
        c.start_offset = irfp_pkg::RST_START_OFFSET;
        return c;
    endfunction

    // register write as the block sees it; counters reload at once
    task automatic store_register(input irfp_pkg::t_cfg_idx idx,
                                  input logic [irfp_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            irfp_pkg::REG_CREATED_MIN:  regs.created_min  = value[irfp_pkg::TIME_W-1:0];
            irfp_pkg::REG_CREATED_MAX:  regs.created_max  = value[irfp_pkg::TIME_W-1:0];
            irfp_pkg::REG_MODIFIED_MIN: regs.modified_min = value[irfp_pkg::TIME_W-1:0];
            irfp_pkg::REG_MODIFIED_MAX: regs.modified_max = value[irfp_pkg::TIME_W-1:0];
            irfp_pkg::REG_PIXEL_BOUNDS: regs.pixel_bounds = value[irfp_pkg::BOUNDS_W-1:0];
            irfp_pkg::REG_FILTER_MODE:  regs.filter_mode  = value[irfp_pkg::MODE_W-1:0];
            irfp_pkg::REG_MAX_RETURNED: begin
                regs.max_returned = value[irfp_pkg::COUNT_W-1:0];
                return_cnt        = value[irfp_pkg::COUNT_W-1:0];
            end
            irfp_pkg::REG_START_OFFSET: begin
                regs.start_offset = value[irfp_pkg::COUNT_W-1:0];
                skip_cnt          = value[irfp_pkg::COUNT_W-1:0];
            end
            default: ;
        endcase
    endtask

    // every enabled time and encoding check, the size box, and when enabled the aspect ratio of the largest size
    function automatic bit record_in_bounds(input irfp_pkg::t_record r);
        logic [irfp_pkg::PIXEL_W-1:0] minw, minh, maxw, maxh;
        longint unsigned              lhs, rhs;
        minw = regs.pixel_bounds[0*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        minh = regs.pixel_bounds[1*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        maxw = regs.pixel_bounds[2*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        maxh = regs.pixel_bounds[3*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        lhs  = 64'(maxh) * 64'(r.pixel_width);
        rhs  = 64'(maxw) * 64'(r.pixel_height);
        if (regs.filter_mode[irfp_pkg::FM_CREATED_MIN] && r.created_time < regs.created_min)
            return 1'b0;
        if (regs.filter_mode[irfp_pkg::FM_CREATED_MAX] && r.created_time > regs.created_max)
            return 1'b0;
        if (regs.filter_mode[irfp_pkg::FM_MODIFIED_MIN] &&
            r.modified_time < regs.modified_min)
            return 1'b0;
        if (regs.filter_mode[irfp_pkg::FM_MODIFIED_MAX] &&
            r.modified_time > regs.modified_max)
            return 1'b0;
        if (regs.filter_mode[irfp_pkg::FM_ENC_CHECK] &&
            r.encoding_code != regs.filter_mode[irfp_pkg::FM_ENC_LSB +: irfp_pkg::ENC_W])
            return 1'b0;
        if (minw > r.pixel_width || minh > r.pixel_height)
            return 1'b0;
        if (maxw < r.pixel_width || maxh < r.pixel_height)
            return 1'b0;
        if (regs.filter_mode[irfp_pkg::FM_FIXED_RATIO] && lhs != rhs)
            return 1'b0;
        return 1'b1;
    endfunction

    // skip, return or drop one record; summary and counter reload on list end
    task automatic paginate_record(input irfp_pkg::t_record r);
        irfp_pkg::t_result ent;
        bit                pass;
        pass = (return_cnt != 0) && record_in_bounds(r);
        if (pass) begin
            if (skip_cnt == 0) begin
                ent.result_kind     = irfp_pkg::RK_HANDLE;
                ent.returned_handle = r.image_handle;
                ent.returned_count  = '0;
                ent.run_last        = !r.list_end;
                listing_entries.push_back(ent);
                if (returned_total != irfp_pkg::COUNT_SAT)
                    returned_total++;
                return_cnt--;
            end else begin
                skip_cnt--;
            end
        end
        if (r.list_end) begin
            ent.result_kind     = irfp_pkg::RK_SUMMARY;
            ent.returned_handle = '0;
            ent.returned_count  = returned_total;
            ent.run_last        = 1'b1;
            listing_entries.push_back(ent);
            skip_cnt       = regs.start_offset;
            return_cnt     = regs.max_returned;
            returned_total = '0;
        end
    endtask

    // write the masked registers, one per cycle; unused upper data bits are random
    task automatic apply_config(input irfp_pkg::t_cfg c, input logic [7:0] mask);
        logic [irfp_pkg::CFG_DATA_W-1:0] data;
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                data = {$urandom, $urandom};
                case (irfp_pkg::t_cfg_idx'(i))
                    irfp_pkg::REG_CREATED_MIN:
                        data[irfp_pkg::TIME_W-1:0] = c.created_min;
                    irfp_pkg::REG_CREATED_MAX:
                        data[irfp_pkg::TIME_W-1:0] = c.created_max;
                    irfp_pkg::REG_MODIFIED_MIN:
                        data[irfp_pkg::TIME_W-1:0] = c.modified_min;
                    irfp_pkg::REG_MODIFIED_MAX:
                        data[irfp_pkg::TIME_W-1:0] = c.modified_max;
                    irfp_pkg::REG_PIXEL_BOUNDS:
                        data = c.pixel_bounds;
                    irfp_pkg::REG_FILTER_MODE:
                        data[irfp_pkg::MODE_W-1:0] = c.filter_mode;
                    irfp_pkg::REG_MAX_RETURNED:
                        data[irfp_pkg::COUNT_W-1:0] = c.max_returned;
                    irfp_pkg::REG_START_OFFSET:
                        data[irfp_pkg::COUNT_W-1:0] = c.start_offset;
                    default: ;
                endcase
                cfg_we    <= 1'b1;
                cfg_idx   <= irfp_pkg::CFG_IDX_W'(i);
                cfg_wdata <= data;
                @(posedge i_clk);
                store_register(irfp_pkg::t_cfg_idx'(i), data);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // offer one record after a random gap; valid stays up for a back-to-back follower
    task automatic send_record(input irfp_pkg::t_record r);
        int gap;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap > 0) begin
            rec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rec_if.valid <= 1'b1;
        rec_if.data  <= r;
        @(posedge i_clk);
        while (!rec_if.ready)
            @(posedge i_clk);
        sent_records++;
        paginate_record(r);
    endtask

    // stop offering, let every pending result out, then cover records still in flight
    task automatic wait_listing_drained();
        rec_if.valid <= 1'b0;
        while (listing_entries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic irfp_pkg::t_record rec_of(
        input logic [irfp_pkg::HANDLE_W-1:0] handle,
        input logic [irfp_pkg::TIME_W-1:0]   ct,
        input logic [irfp_pkg::TIME_W-1:0]   mt,
        input logic [irfp_pkg::ENC_W-1:0]    enc,
        input logic [irfp_pkg::PIXEL_W-1:0]  w,
        input logic [irfp_pkg::PIXEL_W-1:0]  h,
        input logic                          last);
        irfp_pkg::t_record r;
        r.image_handle  = handle;
        r.created_time  = ct;
        r.modified_time = mt;
        r.encoding_code = enc;
        r.pixel_width   = w;
        r.pixel_height  = h;
        r.list_end      = last;
        return r;
    endfunction

    function automatic int unsigned common_divisor(input int unsigned a, input int unsigned b);
        int unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // value inside a window, on either edge or just outside it
    function automatic logic [31:0] near_window(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // {upper, lower}; now and then upper below lower, an empty window
    function automatic logic [63:0] bound_pair(input logic [31:0] mask);
        logic [31:0] a, b;
        a = $urandom & mask;
        b = $urandom & mask;
        if (a > b && $urandom_range(0, 9) != 0)
            return {a, b};
        return {b, a};
    endfunction

    // mostly records aimed at the current bounds, the rest plain noise
    function automatic irfp_pkg::t_record random_record(input logic last);
        irfp_pkg::t_record r;
        int unsigned       minw, minh, maxw, maxh, g, m;
        r.image_handle = irfp_pkg::HANDLE_W'($urandom_range(9999999, 0));
        r.list_end     = last;
        if ($urandom_range(0, 4) == 0) begin
            r.created_time  = $urandom;
            r.modified_time = $urandom;
            r.encoding_code = irfp_pkg::ENC_W'($urandom);
            r.pixel_width   = irfp_pkg::PIXEL_W'($urandom);
            r.pixel_height  = irfp_pkg::PIXEL_W'($urandom);
            return r;
        end
        minw = regs.pixel_bounds[0*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        minh = regs.pixel_bounds[1*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        maxw = regs.pixel_bounds[2*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        maxh = regs.pixel_bounds[3*irfp_pkg::PIXEL_W +: irfp_pkg::PIXEL_W];
        r.created_time  = near_window(regs.created_min, regs.created_max);
        r.modified_time = near_window(regs.modified_min, regs.modified_max);
        if ($urandom_range(0, 7) == 0)
            r.encoding_code = irfp_pkg::ENC_W'($urandom);
        else
            r.encoding_code = regs.filter_mode[irfp_pkg::FM_ENC_LSB +: irfp_pkg::ENC_W];
        if (regs.filter_mode[irfp_pkg::FM_FIXED_RATIO] && $urandom_range(0, 3) != 0) begin
            // scale the reduced max size so the products match
            g = common_divisor(maxw, maxh);
            if (g == 0) begin
                r.pixel_width  = '0;
                r.pixel_height = '0;
            end else begin
                m = ($urandom_range(0, 1) == 0) ? g : $urandom_range(g, 1);
                r.pixel_width  = irfp_pkg::PIXEL_W'((maxw / g) * m);
                r.pixel_height = irfp_pkg::PIXEL_W'((maxh / g) * m);
            end
        end else begin
            r.pixel_width  = irfp_pkg::PIXEL_W'(near_window(minw, maxw));
            r.pixel_height = irfp_pkg::PIXEL_W'(near_window(minh, maxh));
        end
        return r;
    endfunction

    function automatic irfp_pkg::t_cfg random_settings();
        irfp_pkg::t_cfg c;
        logic [31:0]    lo_w, hi_w, lo_h, hi_h;
        c = open_config();
        case ($urandom_range(0, 9))
            0: c.filter_mode = irfp_pkg::MODE_W'($urandom);
            1: c = '1;
            2: c = '0;
            default: begin
                {c.created_max, c.created_min}   = bound_pair(32'hFFFF_FFFF);
                {c.modified_max, c.modified_min} = bound_pair(32'hFFFF_FFFF);
                {hi_w, lo_w} = bound_pair(32'h0000_FFFF);
                {hi_h, lo_h} = bound_pair(32'h0000_FFFF);
                c.pixel_bounds = {hi_h[irfp_pkg::PIXEL_W-1:0], hi_w[irfp_pkg::PIXEL_W-1:0],
                                  lo_h[irfp_pkg::PIXEL_W-1:0], lo_w[irfp_pkg::PIXEL_W-1:0]};
                c.filter_mode  = irfp_pkg::MODE_W'($urandom);
                case ($urandom_range(0, 7))
                    0:       c.max_returned = '0;
                    1:       c.max_returned = irfp_pkg::COUNT_SAT;
                    2:       c.max_returned = irfp_pkg::COUNT_W'($urandom);
                    default: c.max_returned = irfp_pkg::COUNT_W'($urandom_range(10, 1));
                endcase
                if ($urandom_range(0, 9) == 0)
                    c.start_offset = irfp_pkg::COUNT_W'($urandom);
                else
                    c.start_offset = irfp_pkg::COUNT_W'($urandom_range(4, 0));
            end
        endcase
        return c;
    endfunction

    // receiver: random wait after each transfer, long hold-off when asked
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                res_if.ready <= 1'b0;
                rx_hold--;
            end else if (res_if.valid && res_if.ready) begin
                rx_wait = $urandom_range(rx_idle_max, 0);
                res_if.ready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_if.ready <= (rx_wait == 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input irfp_pkg::t_result want,
                                   input irfp_pkg::t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"cycle %0d %s: expected kind=%0d handle=%0d count=%0d last=%0b, ",
                      "got kind=%0d handle=%0d count=%0d last=%0b"},
                     cycle_count, what,
                     want.result_kind, want.returned_handle, want.returned_count, want.run_last,
                     got.result_kind, got.returned_handle, got.returned_count, got.run_last);
    endtask

    // every result transfer against the oldest pending entry; also the run limit
    always @(posedge i_clk) begin : check_results
        irfp_pkg::t_result want;
        irfp_pkg::t_result got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (listing_entries.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got);
            end else begin
                want = listing_entries.pop_front();
                if (got.result_kind !== want.result_kind ||
                    got.returned_handle !== want.returned_handle ||
                    got.returned_count !== want.returned_count ||
                    got.run_last !== want.run_last)
                    report_mismatch("result differs", want, got);
            end
        end
    end

    // reset register values: everything passes, sizes at their extremes, handles 0 and 9999999
    task automatic test_reset_defaults();
        send_record(rec_of('0, '0, '0, '0, '0, '0, 1'b0));
        send_record(rec_of(24'd9999999, '1, '1, '1, '1, '1, 1'b0));
        send_record(rec_of(24'h5A5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'hA, 16'h5555, 16'hAAAA,
                           1'b1));
        wait_listing_drained();
    endtask

    // each bound enabled, records on and just past every time edge, and past the size limits
    task automatic test_filter_bounds();
        irfp_pkg::t_cfg c;
        c = open_config();
        c.created_min  = 32'd100;
        c.created_max  = 32'd200;
        c.modified_min = 32'd1000;
        c.modified_max = 32'd2000;
        c.pixel_bounds = {16'd480, 16'd640, 16'd20, 16'd10};
        c.filter_mode  = {4'd5, 6'h3F};
        apply_config(c, ALL_REGS);
        send_record(rec_of(24'd1, 32'd100, 32'd1500, 4'd5, 16'd320, 16'd240, 1'b0));
        send_record(rec_of(24'd2, 32'd99, 32'd1500, 4'd5, 16'd320, 16'd240, 1'b0));
        send_record(rec_of(24'd3, 32'd201, 32'd1500, 4'd5, 16'd320, 16'd240, 1'b0));
        send_record(rec_of(24'd4, 32'd200, 32'd1000, 4'd5, 16'd640, 16'd480, 1'b0));
        send_record(rec_of(24'd5, 32'd150, 32'd999, 4'd5, 16'd320, 16'd240, 1'b0));
        send_record(rec_of(24'd6, 32'd150, 32'd2001, 4'd5, 16'd320, 16'd240, 1'b0));
        // wrong encoding
        send_record(rec_of(24'd7, 32'd150, 32'd2000, 4'd4, 16'd320, 16'd240, 1'b0));
        // right ratio, below min width, then below min height
        send_record(rec_of(24'd8, 32'd150, 32'd1500, 4'd5, 16'd8, 16'd6, 1'b0));
        send_record(rec_of(24'd9, 32'd150, 32'd1500, 4'd5, 16'd16, 16'd12, 1'b0));
        // in the box, wrong ratio
        send_record(rec_of(24'd10, 32'd150, 32'd1500, 4'd5, 16'd320, 16'd241, 1'b0));
        // right ratio, above the max size
        send_record(rec_of(24'd11, 32'd150, 32'd1500, 4'd5, 16'd644, 16'd483, 1'b0));
        send_record(rec_of(24'd12, 32'd150, 32'd1500, 4'd5, 16'd40, 16'd30, 1'b1));
        wait_listing_drained();
    endtask

    // zero max_returned, offset skipping, counter reload in the middle of a listing
    task automatic test_paging_limits();
        irfp_pkg::t_cfg c;
        c = open_config();
        c.max_returned = '0;
        apply_config(c, ALL_REGS);
        send_record(random_record(1'b0));
        send_record(random_record(1'b0));
        send_record(random_record(1'b1));
        wait_listing_drained();
        c.max_returned = 16'd2;
        c.start_offset = 16'd2;
        apply_config(c, COUNTER_REGS);
        repeat (3) send_record(random_record(1'b0));
        wait_listing_drained();
        // reload both counters mid-listing; the running total is kept
        c.max_returned = 16'd1;
        c.start_offset = 16'd1;
        apply_config(c, COUNTER_REGS);
        send_record(random_record(1'b0));
        send_record(random_record(1'b0));
        send_record(random_record(1'b1));
        wait_listing_drained();
    endtask

    // receiver holds off while records keep coming, so the input must stall
    task automatic test_output_backpressure();
        apply_config(open_config(), ALL_REGS);
        tx_idle_max = 0;
        rx_idle_max = 0;
        rx_hold     = RX_HOLD_LEN;
        for (int k = 1; k <= 40; k++)
            send_record(random_record(k == 40));
        wait_listing_drained();
    endtask

    // phases of random settings and listings, idling mixed per phase
    task automatic test_random_listings();
        irfp_pkg::t_cfg c;
        int             n_lists, len, split;
        while (sent_records < TOTAL_ITEMS) begin
            c = random_settings();
            apply_config(c, ALL_REGS);
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            n_lists = $urandom_range(4, 1);
            repeat (n_lists) begin
                len   = $urandom_range(24, 1);
                split = ($urandom_range(0, 4) == 0) ? $urandom_range(len, 1) : 0;
                for (int k = 1; k <= len; k++) begin
                    if (k == split) begin
                        wait_listing_drained();
                        c.max_returned = irfp_pkg::COUNT_W'($urandom_range(6, 0));
                        c.start_offset = irfp_pkg::COUNT_W'($urandom_range(3, 0));
                        case ($urandom_range(0, 2))
                            0:       apply_config(c, MAX_RET_REG);
                            1:       apply_config(c, OFFSET_REG);
                            default: apply_config(c, COUNTER_REGS);
                        endcase
                    end
                    send_record(random_record(k == len));
                end
            end
            wait_listing_drained();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        rec_if.valid <= 1'b0;
        rec_if.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_wdata    <= '0;
        regs           = open_config();
        skip_cnt       = irfp_pkg::RST_START_OFFSET;
        return_cnt     = irfp_pkg::RST_MAX_RETURNED;
        returned_total = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_filter_bounds();
        test_paging_limits();
        test_output_backpressure();
        test_random_listings();

        // every test ends drained; a little more time for stray results
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && listing_entries.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
